// ===== rtl/core/imh_pkg.sv =====
// shared types, sizes and codes for the indexed minimum heap
// depends on nothing; used by every file in rtl/core
package imh_pkg;

   localparam int CAPACITY     = 1024;
   localparam int KEY_BITS     = 32;
   localparam int HANDLE_SPACE = 1024;
   localparam int HANDLE_BITS  = $clog2(HANDLE_SPACE);
   localparam int SLOT_BITS    = $clog2(CAPACITY);
   localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
   // child index arithmetic needs room for 2*slot+2
   localparam int IDX_BITS     = SLOT_BITS + 2;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_INSERT  = 2'd0;
   localparam mode_type MODE_EXTRACT = 2'd1;
   localparam mode_type MODE_DELETE  = 2'd2;
   localparam mode_type MODE_UPDATE  = 2'd3;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_EMPTY   = 3'd1;
   localparam status_type ST_FULL    = 3'd2;
   localparam status_type ST_ABSENT  = 3'd3;
   localparam status_type ST_PRESENT = 3'd4;

   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [HANDLE_BITS-1:0] handle;
   } slot_entry_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] addr;
      slot_entry_type       data;
   } slot_wr_type;

   typedef struct packed {
      logic                 present;
      logic [SLOT_BITS-1:0] pos;
   } pos_entry_type;

   typedef struct packed {
      logic                   en;
      logic [HANDLE_BITS-1:0] addr;
      pos_entry_type          data;
   } pos_wr_type;

endpackage

// ===== rtl/core/imh_slot_ram.sv =====
// heap slot store: key and handle per slot, one write and two read ports
// depends on imh_pkg
module imh_slot_ram (
   input  logic                           clock,
   input  imh_pkg::slot_wr_type           wr,
   input  logic [imh_pkg::SLOT_BITS-1:0]  rd_addr_a,
   input  logic [imh_pkg::SLOT_BITS-1:0]  rd_addr_b,
   output imh_pkg::slot_entry_type        rd_data_a,
   output imh_pkg::slot_entry_type        rd_data_b
);
   import imh_pkg::*;

   slot_entry_type mem [CAPACITY];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== rtl/core/imh_pos_ram.sv =====
// handle table: present flag and heap slot per handle
// depends on imh_pkg
module imh_pos_ram (
   input  logic                            clock,
   input  imh_pkg::pos_wr_type             wr,
   input  logic [imh_pkg::HANDLE_BITS-1:0] rd_addr,
   output imh_pkg::pos_entry_type          rd_data
);
   import imh_pkg::*;

   pos_entry_type mem [HANDLE_SPACE];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/indexed_min_heap.sv =====
// indexed binary min-heap: sequencer over the slot store and handle table
// depends on imh_pkg, imh_slot_ram, imh_pos_ram
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_mode, req_handle, req_key
//  rsp      out        rsp_valid/rsp_stall  rsp_out_handle, rsp_out_key, rsp_status, rsp_fill
//
// one transaction at a time: an accept, a lookup (S_READ, S_CHECK), for each level
// walked by each sift one memory read and one compare and write back, then a
// commit and a hand-over; a rejected transaction skips the sift and the commit.
// after reset a pass over every handle clears the handle table; req_stall is
// high meanwhile. a finished result waits in the output register while the next
// transaction is taken in.
module indexed_min_heap (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [imh_pkg::HANDLE_BITS-1:0] req_handle,
   input  logic [31:0]                     req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [9:0]                      rsp_out_handle,
   output logic [31:0]                     rsp_out_key,
   output logic [2:0]                      rsp_status,
   output logic [10:0]                     rsp_fill
);
   import imh_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b00_0000_0001,
      S_IDLE     = 10'b00_0000_0010,
      S_READ     = 10'b00_0000_0100,
      S_CHECK    = 10'b00_0000_1000,
      S_DOWN_RD  = 10'b00_0001_0000,
      S_DOWN_CMP = 10'b00_0010_0000,
      S_UP_RD    = 10'b00_0100_0000,
      S_UP_CMP   = 10'b00_1000_0000,
      S_COMMIT   = 10'b01_0000_0000,
      S_DONE     = 10'b10_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [HANDLE_BITS-1:0] clr_ff, clr_in;
   mode_type               mode_ff, mode_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [KEY_BITS-1:0]    mkey_ff, mkey_in;
   logic [HANDLE_BITS-1:0] mhandle_ff, mhandle_in;
   logic [SLOT_BITS-1:0]   hole_ff, hole_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   r_ok_ff, r_ok_in;
   logic [HANDLE_BITS-1:0] res_handle_ff, res_handle_in;
   logic [KEY_BITS-1:0]    res_key_ff, res_key_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [KEY_BITS-1:0]    rsp_key_ff, rsp_key_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0]  rsp_fill_ff, rsp_fill_in;

   slot_wr_type            slot_wr;
   logic [SLOT_BITS-1:0]   slot_rd_a, slot_rd_b;
   slot_entry_type         slot_q_a, slot_q_b;
   pos_wr_type             pos_wr;
   logic [HANDLE_BITS-1:0] pos_rd;
   pos_entry_type          pos_q;

   logic [IDX_BITS-1:0]    left_idx, right_idx, count_ext, last_ext;
   logic [SLOT_BITS-1:0]   parent_idx, min_idx;
   logic [KEY_BITS-1:0]    min_key;
   logic                   out_free;

   imh_slot_ram u_slot_ram (
      .clock     (clock),
      .wr        (slot_wr),
      .rd_addr_a (slot_rd_a),
      .rd_addr_b (slot_rd_b),
      .rd_data_a (slot_q_a),
      .rd_data_b (slot_q_b)
   );

   imh_pos_ram u_pos_ram (
      .clock   (clock),
      .wr      (pos_wr),
      .rd_addr (pos_rd),
      .rd_data (pos_q)
   );

   // tree index arithmetic
   assign left_idx   = {1'b0, hole_ff, 1'b1};
   assign right_idx  = IDX_BITS'({hole_ff, 1'b1}) + IDX_BITS'(1);
   assign parent_idx = SLOT_BITS'((hole_ff - SLOT_BITS'(1)) >> 1);
   assign count_ext  = IDX_BITS'(count_ff);
   assign last_ext   = count_ext - IDX_BITS'(1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // smallest of moving entry and its two children
   always_comb begin
      min_idx = hole_ff;
      min_key = mkey_ff;
      if (slot_q_a.key < min_key) begin
         min_idx = left_idx[SLOT_BITS-1:0];
         min_key = slot_q_a.key;
      end
      if (r_ok_ff && (slot_q_b.key < min_key)) begin
         min_idx = right_idx[SLOT_BITS-1:0];
         min_key = slot_q_b.key;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      handle_in     = handle_ff;
      key_in        = key_ff;
      mkey_in       = mkey_ff;
      mhandle_in    = mhandle_ff;
      hole_in       = hole_ff;
      count_in      = count_ff;
      r_ok_in       = r_ok_ff;
      res_handle_in = res_handle_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_handle_in = rsp_handle_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      slot_wr       = '0;
      pos_wr        = '0;
      slot_rd_a     = '0;
      slot_rd_b     = last_ext[SLOT_BITS-1:0];
      pos_rd        = handle_ff;
      req_stall     = 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            pos_wr.en   = 1'b1;
            pos_wr.addr = clr_ff;
            clr_in      = clr_ff + HANDLE_BITS'(1);
            if (clr_ff == HANDLE_BITS'(HANDLE_SPACE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in   = mode_type'(req_mode);
               handle_in = req_handle;
               key_in    = req_key[KEY_BITS-1:0];
               state_in  = S_READ;
            end
         end
         S_READ: begin
            // look up handle, root and last slot
            state_in = S_CHECK;
         end
         S_CHECK: begin
            res_handle_in = handle_ff;
            res_key_in    = '0;
            res_status_in = ST_OK;
            state_in      = S_DONE;
            unique case (mode_ff)
               MODE_INSERT: begin
                  if (pos_q.present) begin
                     res_status_in = ST_PRESENT;
                  end else if (count_ff == COUNT_BITS'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mkey_in    = key_ff;
                     mhandle_in = handle_ff;
                     hole_in    = count_ff[SLOT_BITS-1:0];
                     count_in   = count_ff + COUNT_BITS'(1);
                     state_in   = S_UP_RD;
                  end
               end
               MODE_EXTRACT: begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     res_handle_in = slot_q_a.handle;
                     res_key_in    = slot_q_a.key;
                     pos_wr.en     = 1'b1;
                     pos_wr.addr   = slot_q_a.handle;
                     count_in      = count_ff - COUNT_BITS'(1);
                     mkey_in       = slot_q_b.key;
                     mhandle_in    = slot_q_b.handle;
                     hole_in       = '0;
                     if (count_ff != COUNT_BITS'(1)) begin
                        state_in = S_DOWN_RD;
                     end
                  end
               end
               default: begin
                  if (!pos_q.present || (COUNT_BITS'(pos_q.pos) >= count_ff)) begin
                     res_status_in = ST_ABSENT;
                  end else if (mode_ff == MODE_DELETE) begin
                     pos_wr.en   = 1'b1;
                     pos_wr.addr = handle_ff;
                     count_in    = count_ff - COUNT_BITS'(1);
                     mkey_in     = slot_q_b.key;
                     mhandle_in  = slot_q_b.handle;
                     hole_in     = pos_q.pos;
                     if (IDX_BITS'(pos_q.pos) != last_ext) begin
                        state_in = S_DOWN_RD;
                     end
                  end else begin
                     mkey_in    = key_ff;
                     mhandle_in = handle_ff;
                     hole_in    = pos_q.pos;
                     state_in   = S_DOWN_RD;
                  end
               end
            endcase
         end
         S_DOWN_RD: begin
            slot_rd_a = left_idx[SLOT_BITS-1:0];
            slot_rd_b = right_idx[SLOT_BITS-1:0];
            r_ok_in   = right_idx < count_ext;
            if (left_idx < count_ext) begin
               state_in = S_DOWN_CMP;
            end else begin
               state_in = S_UP_RD;
            end
         end
         S_DOWN_CMP: begin
            // pull the smaller child into the hole
            if (min_idx != hole_ff) begin
               slot_wr.en  = 1'b1;
               slot_wr.addr = hole_ff;
               slot_wr.data = (min_idx == left_idx[SLOT_BITS-1:0]) ? slot_q_a : slot_q_b;
               pos_wr.en   = 1'b1;
               pos_wr.addr = slot_wr.data.handle;
               pos_wr.data = '{present: 1'b1, pos: hole_ff};
               hole_in     = min_idx;
               state_in    = S_DOWN_RD;
            end else begin
               state_in = S_UP_RD;
            end
         end
         S_UP_RD: begin
            slot_rd_a = parent_idx;
            if (hole_ff == '0) begin
               state_in = S_COMMIT;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // pull the larger parent down into the hole
            if (mkey_ff < slot_q_a.key) begin
               slot_wr.en   = 1'b1;
               slot_wr.addr = hole_ff;
               slot_wr.data = slot_q_a;
               pos_wr.en    = 1'b1;
               pos_wr.addr  = slot_q_a.handle;
               pos_wr.data  = '{present: 1'b1, pos: hole_ff};
               hole_in      = parent_idx;
               state_in     = S_UP_RD;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            slot_wr.en   = 1'b1;
            slot_wr.addr = hole_ff;
            slot_wr.data = '{key: mkey_ff, handle: mhandle_ff};
            pos_wr.en    = 1'b1;
            pos_wr.addr  = mhandle_ff;
            pos_wr.data  = '{present: 1'b1, pos: hole_ff};
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = res_handle_ff;
               rsp_key_in    = res_key_ff;
               rsp_status_in = res_status_ff;
               rsp_fill_in   = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      handle_ff     <= handle_in;
      key_ff        <= key_in;
      mkey_ff       <= mkey_in;
      mhandle_ff    <= mhandle_in;
      hole_ff       <= hole_in;
      r_ok_ff       <= r_ok_in;
      res_handle_ff <= res_handle_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_out_key    = rsp_key_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill       = rsp_fill_ff;

endmodule

// ===== tb/indexed_min_heap_checker.sv =====
// scoreboard for the indexed min-heap: watches both channels, predicts, compares
// depends on imh_pkg
module indexed_min_heap_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [9:0]  req_handle,
   input  logic [31:0] req_key,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [9:0]  rsp_out_handle,
   input  logic [31:0] rsp_out_key,
   input  logic [2:0]  rsp_status,
   input  logic [10:0] rsp_fill,
   output int          fail_count,
   output int          pending_count,
   output logic        accepted
);
   timeunit 1ns;
   timeprecision 1ps;
   import imh_pkg::*;

   typedef struct packed {
      logic [9:0]  handle;
      logic [31:0] key;
      status_type  status;
      logic [10:0] fill;
   } heap_reply_type;

   // model copy of the heap
   logic [31:0] heap_key [CAPACITY];
   logic [9:0]  heap_handle [CAPACITY];
   int          handle_slot [HANDLE_SPACE];
   bit          handle_live [HANDLE_SPACE];
   int          heap_size;
   heap_reply_type expected_replies[$];

   function automatic void swap_entries(int a, int b);
      logic [31:0] k;
      logic [9:0]  h;
      k = heap_key[a]; h = heap_handle[a];
      heap_key[a] = heap_key[b]; heap_handle[a] = heap_handle[b];
      heap_key[b] = k; heap_handle[b] = h;
      handle_slot[heap_handle[a]] = a;
      handle_slot[heap_handle[b]] = b;
   endfunction

   function automatic int sink(int pos);
      int l, r, m;
      while (pos < heap_size) begin
         l = 2 * pos + 1;
         r = 2 * pos + 2;
         m = pos;
         if (l < heap_size && heap_key[l] < heap_key[m]) m = l;
         if (r < heap_size && heap_key[r] < heap_key[m]) m = r;
         if (m == pos) break;
         swap_entries(pos, m);
         pos = m;
      end
      return pos;
   endfunction

   function automatic void rise(int pos);
      int p;
      while (pos > 0 && pos < heap_size) begin
         p = (pos - 1) / 2;
         if (heap_key[pos] < heap_key[p]) begin
            swap_entries(pos, p);
            pos = p;
         end else break;
      end
   endfunction

   function automatic void drop_slot(int pos);
      int last;
      last = heap_size - 1;
      handle_live[heap_handle[pos]] = 0;
      heap_size = last;
      if (pos != last) begin
         swap_entries(pos, last);
         rise(sink(pos));
      end
   endfunction

   function automatic heap_reply_type apply_request(mode_type mode, logic [9:0] h,
                                                    logic [31:0] k);
      heap_reply_type r;
      r = '{handle: h, key: '0, status: ST_OK, fill: '0};
      case (mode)
         MODE_INSERT: begin
            if (handle_live[h]) r.status = ST_PRESENT;
            else if (heap_size >= CAPACITY) r.status = ST_FULL;
            else begin
               heap_key[heap_size] = k;
               heap_handle[heap_size] = h;
               handle_slot[h] = heap_size;
               handle_live[h] = 1;
               heap_size++;
               rise(heap_size - 1);
            end
         end
         MODE_EXTRACT: begin
            if (heap_size == 0) r.status = ST_EMPTY;
            else begin
               r.handle = heap_handle[0];
               r.key = heap_key[0];
               drop_slot(0);
            end
         end
         default: begin
            if (!handle_live[h] || handle_slot[h] >= heap_size) r.status = ST_ABSENT;
            else if (mode == MODE_DELETE) drop_slot(handle_slot[h]);
            else begin
               heap_key[handle_slot[h]] = k;
               rise(sink(handle_slot[h]));
            end
         end
      endcase
      r.fill = heap_size[10:0];
      return r;
   endfunction

   assign accepted = (req_valid && !req_stall) || (rsp_valid && !rsp_stall);

   // predict on request transactions, compare on response transactions
   always @(posedge clock) begin
      heap_reply_type got, want;
      if (reset) begin
         heap_size = 0;
         foreach (handle_live[i]) handle_live[i] = 0;
         expected_replies.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            want = apply_request(req_mode, req_handle, req_key);
            expected_replies = {expected_replies, want};
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_handle, rsp_out_key, rsp_status, rsp_fill};
            if (expected_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response %p", got);
            end else begin
               want = expected_replies.pop_front();
               if (got != want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p got %p", want, got);
               end
            end
         end
      end
      pending_count = expected_replies.size();
   end
endmodule

// ===== tb/indexed_min_heap_tb.sv =====
// top of the indexed min-heap testbench: clock, reset, stimulus and verdict
// depends on imh_pkg, indexed_min_heap and indexed_min_heap_checker
module indexed_min_heap_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import imh_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_stall;
   logic [1:0]  req_mode = MODE_INSERT;
   logic [9:0]  req_handle = '0;
   logic [31:0] req_key = '0;
   logic        rsp_valid, rsp_stall = 0;
   logic [9:0]  rsp_out_handle;
   logic [31:0] rsp_out_key;
   logic [2:0]  rsp_status;
   logic [10:0] rsp_fill;
   int          fail_count, pending_count;
   logic        accepted;
   int          send_idle_pct = 0, stall_pct = 0;
   bit          hold_off = 0;
   int          quiet_cycles = 0;
   // handles the stimulus believes are in the heap, for well-formed requests
   logic [9:0]  live_handles[$];

   indexed_min_heap dut (.*);
   indexed_min_heap_checker checker_i (.*);

   initial forever #5 clock = ~clock;

   // receiver stalls, with a long hold-off on request
   always @(posedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      quiet_cycles = accepted ? 0 : quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("indexed_min_heap test failed");
         $finish;
      end
   end

   // valid stays high between back-to-back transactions
   task automatic send_request(mode_type m, logic [9:0] h, logic [31:0] k);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1;
      req_mode <= m;
      req_handle <= h;
      req_key <= k;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic stop_sending();
      req_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(3))
         0: return $urandom_range(15);
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   // mostly valid operations on tracked handles, some noise
   task automatic random_request();
      int idx, choice;
      logic [9:0] h;
      choice = $urandom_range(99);
      if (choice < 40 || live_handles.size() == 0) begin
         h = 10'($urandom);
         send_request(MODE_INSERT, h, pick_key());
         if (!(h inside {live_handles}) && live_handles.size() < CAPACITY)
            live_handles = {live_handles, h};
      end else if (choice < 60) begin
         send_request(MODE_EXTRACT, 10'($urandom), $urandom);
         // extracted handle unknown here; forget one at random
         live_handles.delete($urandom_range(live_handles.size() - 1));
      end else if (choice < 75) begin
         idx = $urandom_range(live_handles.size() - 1);
         send_request(MODE_DELETE, live_handles[idx], $urandom);
         live_handles.delete(idx);
      end else if (choice < 92) begin
         idx = $urandom_range(live_handles.size() - 1);
         send_request(MODE_UPDATE, live_handles[idx], pick_key());
      end else
         send_request(mode_type'($urandom_range(3)), 10'($urandom), $urandom);
   endtask

   task automatic wait_drained();
      stop_sending();
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int phase;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty errors, extremes, equal keys, each operation
      send_request(MODE_EXTRACT, 10'd0, '0);
      send_request(MODE_DELETE, 10'd5, '0);
      send_request(MODE_UPDATE, 10'h3FF, '1);
      send_request(MODE_INSERT, 10'h3FF, 32'hFFFF_FFFF);
      send_request(MODE_INSERT, 10'h3FF, 32'd1);
      send_request(MODE_INSERT, 10'd0, 32'd0);
      send_request(MODE_INSERT, 10'd1, 32'd7);
      send_request(MODE_INSERT, 10'd2, 32'd7);
      send_request(MODE_INSERT, 10'h2AA, 32'hAAAA_AAAA);
      send_request(MODE_INSERT, 10'h155, 32'h5555_5555);
      send_request(MODE_UPDATE, 10'h3FF, 32'd0);
      send_request(MODE_UPDATE, 10'd0, 32'hFFFF_FFFE);
      send_request(MODE_DELETE, 10'h155, '0);
      send_request(MODE_DELETE, 10'd0, '0);
      send_request(MODE_DELETE, 10'd0, '0);
      repeat (6) send_request(MODE_EXTRACT, '0, '0);
      send_request(MODE_EXTRACT, '0, '0);
      wait_drained();

      // random phases with varying idle patterns
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 63; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            3: begin send_idle_pct = 8;  stall_pct = 8;  end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         if (phase == 4) begin
            // long receiver hold-off while the sender keeps offering
            fork
               begin
                  hold_off <= 1;
                  repeat (300) @(posedge clock);
                  hold_off <= 0;
               end
               begin
                  repeat (20) random_request();
                  stop_sending();
               end
            join
         end
         repeat (120) random_request();
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("indexed_min_heap test passed");
      else
         $display("indexed_min_heap test failed");
      $finish;
   end
endmodule
